### rtl/core/svl_pkg.sv
// shared types and constants for the stick to velocity slew limiter
// no dependencies; used by every module of the block by scoped names
package svl_pkg;

    localparam int BUTTON_COUNT  = 23;
    localparam int VEL_FRAC_BITS = 12;

    localparam int STICK_W   = 11;
    localparam int SCALE_W   = 15;
    localparam int RATE_W    = 16;
    localparam int ELAPSED_W = 20;
    localparam int VEL_W     = 16;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // products and intermediate widths
    localparam int NUM_W   = 28;  // signed (stick - centre) * scale
    localparam int STEP_P  = RATE_W + ELAPSED_W;
    localparam int STEP_W  = STEP_P - 8;
    localparam int DIV_Y_W = 24;  // (|num| + half span) / 4
    localparam int RECIP_W = 25;
    localparam int RECIP_S = 32;
    localparam int DIV_P_W = DIV_Y_W + RECIP_W;
    localparam int QUOT_W  = DIV_P_W - RECIP_S;

    localparam logic [STICK_W:0]   STICK_CENTRE = 12'd1024;
    localparam logic [25:0]        HALF_SPAN    = 26'd330;
    // divide by 660 as a shift by 2 then multiply by ceil(2^32 / 165)
    localparam logic [RECIP_W-1:0] RECIP_165    = 25'd26030105;

    localparam int NEAR_ZERO_I = ((1 << VEL_FRAC_BITS) + 9999) / 10000;
    localparam logic [VEL_W:0] NEAR_ZERO = (VEL_W + 1)'(NEAR_ZERO_I);

    localparam int SUPPRESS_BIT = 3;

    localparam logic [MODE_W-1:0] MODE_CHASSIS = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ARM     = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FWD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_SIDE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_TURN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_FWD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_SIDE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_TURN  = 3'd5;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 15'd2048;
    localparam logic [RATE_W-1:0]  RATE_RESET  = 16'd1049;

    // stage load strobes from the handshake control
    typedef struct packed {
        logic s1_load;
        logic s2_load;
        logic s3_load;
    } t_pipe_ctl;

endpackage

### rtl/core/svl_axis.sv
// one velocity axis: scale, divide by span, saturate, slew limit
// depends on svl_pkg; three-stage datapath driven by t_pipe_ctl strobes
module svl_axis (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  svl_pkg::t_pipe_ctl                    i_ctl,
    input  logic                                  i_negate,
    input  logic                                  i_suppress,
    input  logic [svl_pkg::STICK_W-1:0]           i_stick,
    input  logic [svl_pkg::ELAPSED_W-1:0]         i_elapsed,
    input  logic [svl_pkg::SCALE_W-1:0]           i_scale,
    input  logic [svl_pkg::RATE_W-1:0]            i_rate,
    output logic signed [svl_pkg::VEL_W-1:0]      o_vel
);

    // stage 1: products
    logic signed [svl_pkg::STICK_W:0]   dev;
    logic signed [svl_pkg::NUM_W-1:0]   n_num;
    logic [svl_pkg::STEP_P-1:0]         step_prod;
    logic signed [svl_pkg::NUM_W-1:0]   r_num;
    logic [svl_pkg::STEP_W-1:0]         r_step1;

    assign dev       = $signed({1'b0, i_stick} - svl_pkg::STICK_CENTRE);
    assign n_num     = svl_pkg::NUM_W'(dev) * $signed(svl_pkg::NUM_W'({1'b0, i_scale}));
    assign step_prod = {{svl_pkg::ELAPSED_W{1'b0}}, i_rate}
                     * {{svl_pkg::RATE_W{1'b0}}, i_elapsed};

    always_ff @(posedge i_clk) begin
        if (i_ctl.s1_load) begin
            r_num   <= n_num;
            r_step1 <= step_prod[svl_pkg::STEP_P-1:8];
        end
    end

    // stage 2: rounded divide by 660 and saturation
    logic [svl_pkg::NUM_W-1:0]          num_abs;
    logic [25:0]                        div_x;
    logic [svl_pkg::DIV_Y_W-1:0]        div_y;
    logic [svl_pkg::DIV_P_W-1:0]        div_p;
    logic [svl_pkg::QUOT_W-1:0]         quot;
    logic                               neg;
    logic signed [svl_pkg::VEL_W-1:0]   n_target;
    logic signed [svl_pkg::VEL_W-1:0]   r_target;
    logic [svl_pkg::STEP_W-1:0]         r_step2;

    assign num_abs = r_num[svl_pkg::NUM_W-1] ? svl_pkg::NUM_W'(-r_num) : r_num;
    assign div_x   = {1'b0, num_abs[24:0]} + svl_pkg::HALF_SPAN;
    assign div_y   = div_x[25:2];
    assign div_p   = {{svl_pkg::RECIP_W{1'b0}}, div_y}
                   * {{svl_pkg::DIV_Y_W{1'b0}}, svl_pkg::RECIP_165};
    assign quot    = div_p[svl_pkg::DIV_P_W-1:svl_pkg::RECIP_S];
    assign neg     = r_num[svl_pkg::NUM_W-1] ^ i_negate;

    always_comb begin
        if (!neg) begin
            n_target = (quot > 17'd32767) ? 16'sh7fff : $signed(quot[15:0]);
        end else begin
            n_target = (quot > 17'd32768) ? 16'sh8000 : $signed(~quot[15:0] + 16'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s2_load) begin
            r_target <= n_target;
            r_step2  <= r_step1;
        end
    end

    // stage 3: slew limit against the last velocity
    logic signed [svl_pkg::VEL_W-1:0]   r_last;
    logic signed [svl_pkg::VEL_W-1:0]   r_vel;
    logic signed [svl_pkg::VEL_W:0]     diff;
    logic [svl_pkg::VEL_W:0]            adiff;
    logic [svl_pkg::VEL_W:0]            tmag;
    logic                               limit;
    logic signed [svl_pkg::VEL_W-1:0]   n_out;

    assign diff  = {r_target[svl_pkg::VEL_W-1], r_target} - {r_last[svl_pkg::VEL_W-1], r_last};
    assign adiff = diff[svl_pkg::VEL_W] ? (svl_pkg::VEL_W + 1)'(-diff) : diff;
    assign tmag  = r_target[svl_pkg::VEL_W-1]
                 ? (svl_pkg::VEL_W + 1)'(-{r_target[svl_pkg::VEL_W-1], r_target})
                 : {1'b0, r_target};
    assign limit = (tmag >= svl_pkg::NEAR_ZERO)
                && ({{(svl_pkg::STEP_W - svl_pkg::VEL_W - 1){1'b0}}, adiff} > r_step2);

    // when limiting, step < |diff| so the result stays between last and target
    always_comb begin
        if (!limit) begin
            n_out = r_target;
        end else if (diff[svl_pkg::VEL_W]) begin
            n_out = r_last - $signed(r_step2[svl_pkg::VEL_W-1:0]);
        end else begin
            n_out = r_last + $signed(r_step2[svl_pkg::VEL_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
        end else if (i_ctl.s3_load) begin
            r_last <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s3_load) begin
            r_vel <= i_suppress ? '0 : n_out;
        end
    end

    assign o_vel = r_vel;

endmodule

### rtl/core/svl_buttons.sv
// button edge toggles and mode enables, carried alongside the axis stages
// depends on svl_pkg; loads on the same t_pipe_ctl strobes as svl_axis
module svl_buttons (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  svl_pkg::t_pipe_ctl                  i_ctl,
    input  logic [svl_pkg::BUTTON_COUNT-1:0]    i_buttons,
    input  logic [svl_pkg::MODE_W-1:0]          i_mode,
    output logic                                o_s2_suppress,
    output logic                                o_command_valid,
    output logic                                o_chassis_on,
    output logic                                o_arm_on,
    output logic [svl_pkg::BUTTON_COUNT-1:0]    o_toggles
);

    logic [svl_pkg::BUTTON_COUNT-1:0] r_prev;
    logic [svl_pkg::BUTTON_COUNT-1:0] r_toggles;
    logic [svl_pkg::BUTTON_COUNT-1:0] n_toggles;
    logic                             n_chassis;
    logic                             n_arm;

    logic [svl_pkg::BUTTON_COUNT-1:0] r_s1_tog;
    logic                             r_s1_chassis;
    logic                             r_s1_arm;
    logic [svl_pkg::BUTTON_COUNT-1:0] r_s2_tog;
    logic                             r_s2_chassis;
    logic                             r_s2_arm;
    logic [svl_pkg::BUTTON_COUNT-1:0] r_s3_tog;
    logic                             r_s3_chassis;
    logic                             r_s3_arm;

    // rising edge flips the toggle
    assign n_toggles = r_toggles ^ (i_buttons & ~r_prev);
    assign n_chassis = (i_mode == svl_pkg::MODE_CHASSIS) || (i_mode == svl_pkg::MODE_ARM);
    assign n_arm     = (i_mode == svl_pkg::MODE_ARM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= '0;
            r_toggles <= '0;
        end else if (i_ctl.s1_load) begin
            r_prev    <= i_buttons;
            r_toggles <= n_toggles;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s1_load) begin
            r_s1_tog     <= n_toggles;
            r_s1_chassis <= n_chassis;
            r_s1_arm     <= n_arm;
        end
        if (i_ctl.s2_load) begin
            r_s2_tog     <= r_s1_tog;
            r_s2_chassis <= r_s1_chassis;
            r_s2_arm     <= r_s1_arm;
        end
        if (i_ctl.s3_load) begin
            r_s3_tog     <= r_s2_tog;
            r_s3_chassis <= r_s2_chassis;
            r_s3_arm     <= r_s2_arm;
        end
    end

    assign o_s2_suppress   = r_s2_tog[svl_pkg::SUPPRESS_BIT];
    assign o_command_valid = ~r_s3_tog[svl_pkg::SUPPRESS_BIT];
    assign o_chassis_on    = r_s3_chassis;
    assign o_arm_on        = r_s3_arm;
    assign o_toggles       = r_s3_tog;

endmodule

### rtl/core/stick_to_velocity_slew_limiter_unit.sv
// an accepted word moves through the products and span divide registers into the output register
// one word per cycle while the output is not stalled; the stage chain is products, span divide, slew limit
// a stalled output holds the result; earlier stages keep filling until the chain is full
// reset (synchronous, active low) clears stage valids, last velocities, button history
// and toggles, and returns the scale and rate registers to their defaults
module stick_to_velocity_slew_limiter_unit (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [svl_pkg::CFG_IDX_W-1:0]            i_cfg_index,
    input  logic [svl_pkg::CFG_DAT_W-1:0]            i_cfg_data,
    input  logic                                     i_in_valid,
    output logic                                     o_in_ready,
    input  logic [svl_pkg::STICK_W-1:0]              i_stick_fwd,
    input  logic [svl_pkg::STICK_W-1:0]              i_stick_side,
    input  logic [svl_pkg::STICK_W-1:0]              i_stick_turn,
    input  logic [svl_pkg::ELAPSED_W-1:0]            i_elapsed_us,
    input  logic [svl_pkg::BUTTON_COUNT-1:0]         i_button_bits,
    input  logic [svl_pkg::MODE_W-1:0]               i_mode_switch,
    output logic                                     o_out_valid,
    input  logic                                     i_out_ready,
    output logic signed [svl_pkg::VEL_W-1:0]         o_vel_fwd,
    output logic signed [svl_pkg::VEL_W-1:0]         o_vel_side,
    output logic signed [svl_pkg::VEL_W-1:0]         o_vel_turn,
    output logic                                     o_command_valid,
    output logic                                     o_chassis_on,
    output logic                                     o_arm_on,
    output logic [svl_pkg::BUTTON_COUNT-1:0]         o_toggle_bits
);

    // configuration registers
    logic [svl_pkg::SCALE_W-1:0] r_scale_fwd;
    logic [svl_pkg::SCALE_W-1:0] r_scale_side;
    logic [svl_pkg::SCALE_W-1:0] r_scale_turn;
    logic [svl_pkg::RATE_W-1:0]  r_rate_fwd;
    logic [svl_pkg::RATE_W-1:0]  r_rate_side;
    logic [svl_pkg::RATE_W-1:0]  r_rate_turn;
    logic                        cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale_fwd  <= svl_pkg::SCALE_RESET;
            r_scale_side <= svl_pkg::SCALE_RESET;
            r_scale_turn <= svl_pkg::SCALE_RESET;
            r_rate_fwd   <= svl_pkg::RATE_RESET;
            r_rate_side  <= svl_pkg::RATE_RESET;
            r_rate_turn  <= svl_pkg::RATE_RESET;
        end else if (cfg_we) begin
            case (i_cfg_index)
                svl_pkg::CFG_SCALE_FWD:  r_scale_fwd  <= i_cfg_data[svl_pkg::SCALE_W-1:0];
                svl_pkg::CFG_SCALE_SIDE: r_scale_side <= i_cfg_data[svl_pkg::SCALE_W-1:0];
                svl_pkg::CFG_SCALE_TURN: r_scale_turn <= i_cfg_data[svl_pkg::SCALE_W-1:0];
                svl_pkg::CFG_RATE_FWD:   r_rate_fwd   <= i_cfg_data;
                svl_pkg::CFG_RATE_SIDE:  r_rate_side  <= i_cfg_data;
                svl_pkg::CFG_RATE_TURN:  r_rate_turn  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage handshake: a stage loads when it is empty or its word moves on
    logic               r_s1_valid;
    logic               r_s2_valid;
    logic               r_out_valid;
    logic               n_s1_valid;
    logic               n_s2_valid;
    logic               n_out_valid;
    logic               s1_ready;
    logic               s2_ready;
    logic               s3_ready;
    svl_pkg::t_pipe_ctl ctl;

    assign s3_ready = ~r_out_valid | i_out_ready;
    assign s2_ready = ~r_s2_valid | s3_ready;
    assign s1_ready = ~r_s1_valid | s2_ready;

    assign ctl.s1_load = i_in_valid & s1_ready;
    assign ctl.s2_load = r_s1_valid & s2_ready;
    assign ctl.s3_load = r_s2_valid & s3_ready;

    assign n_s1_valid  = ctl.s1_load | (r_s1_valid & ~s2_ready);
    assign n_s2_valid  = ctl.s2_load | (r_s2_valid & ~s3_ready);
    assign n_out_valid = ctl.s3_load | (r_out_valid & ~i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_s2_valid  <= n_s2_valid;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = s1_ready;
    assign o_out_valid = r_out_valid;

    logic s2_suppress;

    svl_buttons u_buttons (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .i_buttons       (i_button_bits),
        .i_mode          (i_mode_switch),
        .o_s2_suppress   (s2_suppress),
        .o_command_valid (o_command_valid),
        .o_chassis_on    (o_chassis_on),
        .o_arm_on        (o_arm_on),
        .o_toggles       (o_toggle_bits)
    );

    // forward keeps its sign, side and turn are inverted
    svl_axis u_axis_fwd (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_negate   (1'b0),
        .i_suppress (s2_suppress),
        .i_stick    (i_stick_fwd),
        .i_elapsed  (i_elapsed_us),
        .i_scale    (r_scale_fwd),
        .i_rate     (r_rate_fwd),
        .o_vel      (o_vel_fwd)
    );

    svl_axis u_axis_side (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_negate   (1'b1),
        .i_suppress (s2_suppress),
        .i_stick    (i_stick_side),
        .i_elapsed  (i_elapsed_us),
        .i_scale    (r_scale_side),
        .i_rate     (r_rate_side),
        .o_vel      (o_vel_side)
    );

    svl_axis u_axis_turn (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_negate   (1'b1),
        .i_suppress (s2_suppress),
        .i_stick    (i_stick_turn),
        .i_elapsed  (i_elapsed_us),
        .i_scale    (r_scale_turn),
        .i_rate     (r_rate_turn),
        .o_vel      (o_vel_turn)
    );

endmodule

### rtl/core/svl_checker.sv
// port-level checks for the slew limiter unit, attached by bind
// depends on svl_pkg and stick_to_velocity_slew_limiter_unit
module svl_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [svl_pkg::VEL_W-1:0]    o_vel_fwd,
    input  logic signed [svl_pkg::VEL_W-1:0]    o_vel_side,
    input  logic signed [svl_pkg::VEL_W-1:0]    o_vel_turn,
    input  logic                                o_command_valid,
    input  logic                                o_chassis_on,
    input  logic                                o_arm_on,
    input  logic [svl_pkg::BUTTON_COUNT-1:0]    o_toggle_bits
);

    // a waiting result word is not withdrawn
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped while stalled");

    // suppressed commands carry zero velocity
    a_suppress_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_command_valid |->
            o_vel_fwd == '0 && o_vel_side == '0 && o_vel_turn == '0)
        else $error("suppressed word has nonzero velocity");

    // suppress follows the toggle of the suppress key
    a_suppress_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_command_valid == !o_toggle_bits[svl_pkg::SUPPRESS_BIT])
        else $error("command valid disagrees with suppress toggle");

    a_arm_needs_chassis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_arm_on |-> o_chassis_on)
        else $error("arm enabled without chassis");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind stick_to_velocity_slew_limiter_unit svl_checker u_svl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_vel_fwd       (o_vel_fwd),
    .o_vel_side      (o_vel_side),
    .o_vel_turn      (o_vel_turn),
    .o_command_valid (o_command_valid),
    .o_chassis_on    (o_chassis_on),
    .o_arm_on        (o_arm_on),
    .o_toggle_bits   (o_toggle_bits)
);
